// ----- hdl/dtrfe_pkg.sv -----
`timescale 1ns / 1ps
package dtrfe_pkg;
    localparam int TreeRowsDef   = 2048;
    localparam int MapEntriesDef = 4096;
    localparam int ImgWDef       = 128;
    localparam int ImgHDef       = 128;
    localparam int MaxStepsDef   = 32;
    localparam int TreeCols      = 12;

    localparam logic [2:0] REQ_TREE  = 3'd0;
    localparam logic [2:0] REQ_MAP   = 3'd1;
    localparam logic [2:0] REQ_DEPTH = 3'd2;
    localparam logic [2:0] REQ_MASK  = 3'd3;
    localparam logic [2:0] REQ_EVAL  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIXEL = 2'd1;
    localparam logic [1:0] ST_ROW   = 2'd2;
    localparam logic [1:0] ST_STEPS = 2'd3;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// ----- hdl/dtrfe_div.sv -----
`timescale 1ns / 1ps
// signed 48-bit by unsigned 17-bit restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
module dtrfe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [47:0] i_num,
    input  logic        [16:0] i_den,
    output dtrfe_pkg::t_div_ctl o_ctl,
    output logic signed [47:0] o_quo
);
    logic [47:0] r_q;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;
    logic [18:0] w_sub;

    assign w_trial = {r_rem[16:0], r_q[47]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[47];
            r_q   <= i_num[47] ? -i_num : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[18]) begin
                r_rem <= w_sub[17:0];
                r_q   <= {r_q[46:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[46:0], 1'b0};
            end
        end
    end

    assign o_quo       = r_neg ? -$signed(r_q) : $signed(r_q);
    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
endmodule

// ----- hdl/decision_tree_rect_feature_eval.sv -----
`timescale 1ns / 1ps
// decision tree walker with rectangle depth features over integral images
// command channel: drive the request fields with start high while busy is low;
// that edge transfers the item. write requests (tree word, child map entry,
// depth integral, mask integral) pass through the write state and produce no result.
// an evaluate request walks the tree from start_row; each split reads the row
// from the tree memory one word per cycle, reads eight integral words per
// image, then runs two serial divisions and one child map read. a walk takes
// at most MAX_STEPS splits; the serial divider and the single read port of
// each memory set the pace of a walk.
// the result appears on the o_ ports for one cycle with o_valid high; the
// receiver cannot stall it. busy stays high until the result cycle is over.
// reset clears the control state only; memories hold anything until written.
module decision_tree_rect_feature_eval #(
    parameter int TREE_ROWS   = dtrfe_pkg::TreeRowsDef,
    parameter int MAP_ENTRIES = dtrfe_pkg::MapEntriesDef,
    parameter int IMG_W       = dtrfe_pkg::ImgWDef,
    parameter int IMG_H       = dtrfe_pkg::ImgHDef,
    parameter int MAX_STEPS   = dtrfe_pkg::MaxStepsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [2:0]  i_req_type,
    input  logic        [11:0] i_addr_row,
    input  logic        [6:0]  i_addr_col,
    input  logic signed [31:0] i_write_value,
    input  logic        [10:0] i_start_row,
    input  logic        [6:0]  i_roi_x,
    input  logic        [6:0]  i_roi_y,
    output logic               o_valid,
    output logic        [1:0]  o_status,
    output logic        [10:0] o_leaf_row,
    output logic signed [31:0] o_leaf_fg_prob,
    output logic signed [31:0] o_leaf_trace,
    output logic signed [31:0] o_leaf_mean_0,
    output logic signed [31:0] o_leaf_mean_1,
    output logic signed [31:0] o_leaf_mean_2,
    output logic signed [31:0] o_leaf_mean_3,
    output logic signed [31:0] o_leaf_mean_4,
    output logic signed [31:0] o_leaf_mean_5
);
    localparam int TreeDepth = TREE_ROWS * dtrfe_pkg::TreeCols;
    localparam int TAW = (TreeDepth > 1) ? $clog2(TreeDepth) : 1;
    localparam int MAW = $clog2(MAP_ENTRIES);
    localparam int XW  = $clog2(IMG_W);
    localparam int YW  = $clog2(IMG_H);
    localparam int PAW = $clog2(IMG_W * IMG_H);
    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam int RW  = (TREE_ROWS > 1) ? $clog2(TREE_ROWS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TREAD = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_IREAD = 4'd3;
    localparam logic [3:0] S_SUMS  = 4'd4;
    localparam logic [3:0] S_DIVA  = 4'd5;
    localparam logic [3:0] S_DIVB  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_MAP   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_WRITE = 4'd11;
    localparam logic [3:0] S_DIVAW = 4'd12;
    localparam logic [3:0] S_DIVBW = 4'd13;
    localparam logic [3:0] S_LEAF  = 4'd14;

    logic [31:0] m_tree [TreeDepth];
    logic [11:0] m_map  [MAP_ENTRIES];
    logic [31:0] m_dep  [IMG_W * IMG_H];
    logic [15:0] m_msk  [IMG_W * IMG_H];

    logic [3:0]  r_state;
    logic [2:0]  r_type;
    logic [11:0] r_arow;
    logic [6:0]  r_acol;
    logic [31:0] r_wval;
    logic [6:0]  r_rx, r_ry;
    logic [16:0] r_node;
    logic [1:0]  r_stat;
    logic [SW-1:0] r_steps;
    logic [4:0]  r_cnt;
    logic        r_rdv;
    logic [3:0]  r_rdi;
    logic [31:0] r_tq;
    logic [31:0] r_w [dtrfe_pkg::TreeCols];
    logic [XW-1:0] r_xa1, r_xa2, r_xb1, r_xb2;
    logic [YW-1:0] r_ya1, r_ya2, r_yb1, r_yb2;
    logic [31:0] r_dq;
    logic [15:0] r_mq;
    logic [31:0] r_dv [8];
    logic [15:0] r_mv [8];
    logic signed [47:0] r_numa, r_numb, r_ma, r_mb;
    logic [16:0] r_dena, r_denb;
    logic        r_test;
    logic [11:0] r_mapq;
    logic        r_valid;

    logic [TAW-1:0] w_taddr;
    logic [PAW-1:0] w_paddr;
    logic           w_div_start;
    logic signed [47:0] w_div_num;
    logic [16:0]    w_div_den;
    dtrfe_pkg::t_div_ctl w_dctl;
    logic signed [47:0] w_quo;

    dtrfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_ctl   (w_dctl),
        .o_quo   (w_quo)
    );

    // corner math, signed 35-bit so any word stays exact
    function automatic logic signed [34:0] fsx(input logic [31:0] v);
        fsx = 35'(signed'(v));
    endfunction

    logic signed [34:0] c_xa1, c_ya1, c_xa2, c_ya2, c_xb1, c_yb1, c_xb2, c_yb2;
    logic c_pix_ok;
    always_comb begin
        c_xa1 = 35'(r_rx) + fsx(r_w[2]);
        c_ya1 = 35'(r_ry) + fsx(r_w[3]);
        c_xa2 = c_xa1 + fsx(r_w[6]);
        c_ya2 = c_ya1 + fsx(r_w[7]);
        c_xb1 = 35'(r_rx) + fsx(r_w[4]);
        c_yb1 = 35'(r_ry) + fsx(r_w[5]);
        c_xb2 = c_xb1 + fsx(r_w[8]);
        c_yb2 = c_yb1 + fsx(r_w[9]);
        c_pix_ok = !c_xa1[34] && c_xa1 < IMG_W && !c_ya1[34] && c_ya1 < IMG_H
                && !c_xa2[34] && c_xa2 < IMG_W && !c_ya2[34] && c_ya2 < IMG_H
                && !c_xb1[34] && c_xb1 < IMG_W && !c_yb1[34] && c_yb1 < IMG_H
                && !c_xb2[34] && c_xb2 < IMG_W && !c_yb2[34] && c_yb2 < IMG_H;
    end

    // integral read order: a22 a21 a12 a11 b22 b21 b12 b11
    logic [XW-1:0] c_px;
    logic [YW-1:0] c_py;
    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin c_px = r_xa2; c_py = r_ya2; end
            3'd1: begin c_px = r_xa1; c_py = r_ya2; end
            3'd2: begin c_px = r_xa2; c_py = r_ya1; end
            3'd3: begin c_px = r_xa1; c_py = r_ya1; end
            3'd4: begin c_px = r_xb2; c_py = r_yb2; end
            3'd5: begin c_px = r_xb1; c_py = r_yb2; end
            3'd6: begin c_px = r_xb2; c_py = r_yb1; end
            default: begin c_px = r_xb1; c_py = r_yb1; end
        endcase
    end

    always_comb begin
        if (r_state == S_WRITE) begin
            w_paddr = PAW'(32'(r_arow) * IMG_W + 32'(r_acol));
            w_taddr = TAW'(32'(r_arow) * dtrfe_pkg::TreeCols + 32'(r_acol));
        end else begin
            w_paddr = PAW'(32'(c_py) * IMG_W + 32'(c_px));
            w_taddr = TAW'(32'(r_node) * dtrfe_pkg::TreeCols + 32'(r_cnt));
        end
    end

    // sums and counts
    logic signed [34:0] c_sa, c_sb;
    logic signed [17:0] c_ca, c_cb;
    always_comb begin
        c_sa = fsx(r_dv[0]) - fsx(r_dv[1]) - fsx(r_dv[2]) + fsx(r_dv[3]);
        c_sb = fsx(r_dv[4]) - fsx(r_dv[5]) - fsx(r_dv[6]) + fsx(r_dv[7]);
        c_ca = 18'(r_mv[0]) - 18'(r_mv[1]) - 18'(r_mv[2]) + 18'(r_mv[3]);
        c_cb = 18'(r_mv[4]) - 18'(r_mv[5]) - 18'(r_mv[6]) + 18'(r_mv[7]);
    end

    logic signed [49:0] c_diff;
    logic signed [34:0] c_idx_w;
    always_comb begin
        c_diff  = 50'(r_ma) - 50'(r_mb);
        c_idx_w = (fsx(r_w[0]) <<< 1) - 35'sd1 + 35'(r_test);
    end
    logic c_idx_ok;
    assign c_idx_ok = !c_idx_w[34] && c_idx_w < MAP_ENTRIES;

    assign w_div_start = (r_state == S_DIVA || r_state == S_DIVB);
    assign w_div_num   = (r_state == S_DIVA) ? r_numa : r_numb;
    assign w_div_den   = (r_state == S_DIVA) ? r_dena : r_denb;

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_type == dtrfe_pkg::REQ_TREE
                && r_arow < TREE_ROWS && r_acol < dtrfe_pkg::TreeCols)
            m_tree[w_taddr] <= r_wval;
        r_rdv <= 1'b0;
        if (r_state == S_TREAD && r_cnt < dtrfe_pkg::TreeCols) begin
            r_rdv <= 1'b1;
            r_rdi <= r_cnt[3:0];
            r_tq  <= m_tree[w_taddr];
        end
        if (r_rdv)
            r_w[r_rdi] <= r_tq;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_type == dtrfe_pkg::REQ_MAP && r_arow < MAP_ENTRIES)
            m_map[MAW'(r_arow)] <= r_wval[11:0];
        r_mapq <= m_map[MAW'(c_idx_w)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_arow < IMG_H && r_acol < IMG_W) begin
            if (r_type == dtrfe_pkg::REQ_DEPTH)
                m_dep[w_paddr] <= r_wval;
            if (r_type == dtrfe_pkg::REQ_MASK)
                m_msk[w_paddr] <= r_wval[15:0];
        end
        r_dq <= m_dep[w_paddr];
        r_mq <= m_msk[w_paddr];
    end

    // control
    logic [RW-1:0] c_nrow;
    assign c_nrow = RW'(r_mapq - 12'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_steps <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && !busy) begin
                        r_type <= i_req_type;
                        r_arow <= i_addr_row;
                        r_acol <= i_addr_col;
                        r_wval <= i_write_value;
                        r_rx   <= i_roi_x;
                        r_ry   <= i_roi_y;
                        r_node <= (32'(i_start_row) >= TREE_ROWS) ? '0 : 17'(i_start_row);
                        r_steps <= '0;
                        r_cnt  <= '0;
                        if (i_req_type == dtrfe_pkg::REQ_EVAL) begin
                            if (32'(i_start_row) >= TREE_ROWS) begin
                                r_stat <= dtrfe_pkg::ST_ROW;
                                r_state <= S_OUT;
                            end else begin
                                r_stat <= dtrfe_pkg::ST_OK;
                                r_state <= S_TREAD;
                            end
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_TREAD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(dtrfe_pkg::TreeCols + 1))
                        r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_cnt <= '0;
                    if (r_w[1] != 32'hFFFF_FFFF) begin
                        r_state <= S_LEAF;
                    end else if (32'(r_steps) >= MAX_STEPS) begin
                        r_stat <= dtrfe_pkg::ST_STEPS;
                        r_state <= S_OUT;
                    end else if (!c_pix_ok) begin
                        r_stat <= dtrfe_pkg::ST_PIXEL;
                        r_state <= S_OUT;
                    end else begin
                        r_steps <= r_steps + SW'(1);
                        r_xa1 <= XW'(c_xa1); r_ya1 <= YW'(c_ya1);
                        r_xa2 <= XW'(c_xa2); r_ya2 <= YW'(c_ya2);
                        r_xb1 <= XW'(c_xb1); r_yb1 <= YW'(c_yb1);
                        r_xb2 <= XW'(c_xb2); r_yb2 <= YW'(c_yb2);
                        r_state <= S_IREAD;
                    end
                end
                S_IREAD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0) begin
                        r_dv[r_cnt[2:0] - 3'd1] <= r_dq;
                        r_mv[r_cnt[2:0] - 3'd1] <= r_mq;
                    end
                    if (r_cnt == 5'd8)
                        r_state <= S_SUMS;
                end
                S_SUMS: begin
                    r_numa <= 48'(c_sa) <<< 8;
                    r_numb <= 48'(c_sb) <<< 8;
                    r_dena <= (c_ca < 18'sd1) ? 17'd1 : c_ca[16:0];
                    r_denb <= (c_cb < 18'sd1) ? 17'd1 : c_cb[16:0];
                    r_state <= S_DIVA;
                end
                S_DIVA: r_state <= S_DIVAW;
                S_DIVAW: begin
                    if (w_dctl.done) begin
                        r_ma <= w_quo;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: r_state <= S_DIVBW;
                S_DIVBW: begin
                    if (w_dctl.done) begin
                        r_mb <= w_quo;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_test <= (c_diff >= 50'(fsx(r_w[11])));
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    if (!c_idx_ok) begin
                        r_stat <= dtrfe_pkg::ST_ROW;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_mapq == 12'd0 || 32'(r_mapq) > TREE_ROWS) begin
                        r_stat <= dtrfe_pkg::ST_ROW;
                        r_state <= S_OUT;
                    end else begin
                        r_node <= 17'(c_nrow);
                        r_cnt  <= '0;
                        r_state <= S_TREAD;
                    end
                end
                S_LEAF: r_state <= S_OUT;
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic r_busy_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_busy_out <= 1'b0;
        else
            r_busy_out <= (r_state == S_OUT);
    end

    assign busy    = (r_state != S_IDLE) || r_busy_out;
    assign o_valid = r_valid;
    logic r_ok;
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_status   <= r_stat;
            o_leaf_row <= 11'(r_node);
            r_ok       <= (r_stat == dtrfe_pkg::ST_OK);
        end
    end
    assign o_leaf_fg_prob = r_ok ? r_w[2] : '0;
    assign o_leaf_trace   = r_ok ? r_w[3] : '0;
    assign o_leaf_mean_0  = r_ok ? r_w[4] : '0;
    assign o_leaf_mean_1  = r_ok ? r_w[5] : '0;
    assign o_leaf_mean_2  = r_ok ? r_w[6] : '0;
    assign o_leaf_mean_3  = r_ok ? r_w[7] : '0;
    assign o_leaf_mean_4  = r_ok ? r_w[8] : '0;
    assign o_leaf_mean_5  = r_ok ? r_w[9] : '0;

`ifndef ASSERT_OFF
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_busy_on_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("idle while presenting result");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_steps) <= MAX_STEPS) else $error("step count overrun");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dctl.start |-> !w_dctl.busy) else $error("divider restarted");
`endif
endmodule

// ----- tb/leaf_walk_checker.sv -----
`timescale 1ns / 1ps
module leaf_walk_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic        [2:0]  i_req_type,
    input  logic        [11:0] i_addr_row,
    input  logic        [6:0]  i_addr_col,
    input  logic signed [31:0] i_write_value,
    input  logic        [10:0] i_start_row,
    input  logic        [6:0]  i_roi_x,
    input  logic        [6:0]  i_roi_y,
    input  logic               o_valid,
    input  logic        [1:0]  o_status,
    input  logic        [10:0] o_leaf_row,
    input  logic signed [31:0] o_leaf_fg_prob,
    input  logic signed [31:0] o_leaf_trace,
    input  logic signed [31:0] o_leaf_mean_0,
    input  logic signed [31:0] o_leaf_mean_1,
    input  logic signed [31:0] o_leaf_mean_2,
    input  logic signed [31:0] o_leaf_mean_3,
    input  logic signed [31:0] o_leaf_mean_4,
    input  logic signed [31:0] o_leaf_mean_5,
    output int                 o_mismatches,
    output int                 o_leaves_pending
);
    typedef struct packed {
        logic [1:0]       status;
        logic [10:0]      row;
        logic [7:0][31:0] words;
    } t_leaf_result;

    localparam int ImgPix   = dtrfe_pkg::ImgWDef * dtrfe_pkg::ImgHDef;
    localparam int TreeSize = dtrfe_pkg::TreeRowsDef * dtrfe_pkg::TreeCols;

    logic signed [31:0] tree_mem [TreeSize];
    logic        [11:0] child_mem [dtrfe_pkg::MapEntriesDef];
    logic signed [31:0] depth_img [ImgPix];
    logic        [15:0] mask_img [ImgPix];

    t_leaf_result leaf_q[$];
    int mismatch_count = 0;
    int pending_count = 0;
    string word_names [8] = '{"leaf_fg_prob", "leaf_trace", "leaf_mean_0", "leaf_mean_1",
                              "leaf_mean_2", "leaf_mean_3", "leaf_mean_4", "leaf_mean_5"};

    assign o_mismatches = mismatch_count;
    assign o_leaves_pending = pending_count;

    initial begin
        for (int i = 0; i < TreeSize; i++) tree_mem[i] = '0;
        for (int i = 0; i < dtrfe_pkg::MapEntriesDef; i++) child_mem[i] = '0;
        for (int i = 0; i < ImgPix; i++) begin
            depth_img[i] = '0;
            mask_img[i] = '0;
        end
    end

    function automatic longint tree_word(longint row, int col);
        return longint'(tree_mem[int'(row) * dtrfe_pkg::TreeCols + col]);
    endfunction

    function automatic bit on_image(longint x, longint y);
        return x >= 0 && x < dtrfe_pkg::ImgWDef && y >= 0 && y < dtrfe_pkg::ImgHDef;
    endfunction

    function automatic longint depth_at(longint x, longint y);
        return longint'(depth_img[int'(y) * dtrfe_pkg::ImgWDef + int'(x)]);
    endfunction

    function automatic longint mask_at(longint x, longint y);
        return longint'(mask_img[int'(y) * dtrfe_pkg::ImgWDef + int'(x)]);
    endfunction

    function automatic bit box_mean(longint x1, longint y1, longint x2, longint y2,
                                    output longint mean);
        longint s;
        longint c;
        mean = 0;
        if (!on_image(x1, y1) || !on_image(x2, y2)) return 1'b0;
        s = depth_at(x2, y2) - depth_at(x1, y2) - depth_at(x2, y1) + depth_at(x1, y1);
        c = mask_at(x2, y2) - mask_at(x1, y2) - mask_at(x2, y1) + mask_at(x1, y1);
        if (c < 1) c = 1;
        mean = (s * 256) / c;
        return 1'b1;
    endfunction

    function automatic t_leaf_result walk_tree(logic [10:0] first_row, logic [6:0] rx,
                                               logic [6:0] ry);
        t_leaf_result r;
        longint node;
        longint last;
        longint xa1, ya1, xa2, ya2, xb1, yb1, xb2, yb2;
        longint ma, mb, idx;
        int steps;
        r = '0;
        r.status = dtrfe_pkg::ST_OK;
        node = longint'(first_row);
        last = 0;
        steps = 0;
        if (node >= dtrfe_pkg::TreeRowsDef) begin
            r.status = dtrfe_pkg::ST_ROW;
        end else begin
            while (1) begin
                last = node;
                if (tree_word(node, 1) != -1) break;
                if (steps >= dtrfe_pkg::MaxStepsDef) begin
                    r.status = dtrfe_pkg::ST_STEPS;
                    break;
                end
                steps++;
                xa1 = longint'(rx) + tree_word(node, 2);
                ya1 = longint'(ry) + tree_word(node, 3);
                xa2 = xa1 + tree_word(node, 6);
                ya2 = ya1 + tree_word(node, 7);
                xb1 = longint'(rx) + tree_word(node, 4);
                yb1 = longint'(ry) + tree_word(node, 5);
                xb2 = xb1 + tree_word(node, 8);
                yb2 = yb1 + tree_word(node, 9);
                if (!box_mean(xa1, ya1, xa2, ya2, ma)
                        || !box_mean(xb1, yb1, xb2, yb2, mb)) begin
                    r.status = dtrfe_pkg::ST_PIXEL;
                    break;
                end
                idx = 2 * tree_word(node, 0) - 1 + ((ma - mb >= tree_word(node, 11)) ? 1 : 0);
                if (idx < 0 || idx >= dtrfe_pkg::MapEntriesDef) begin
                    r.status = dtrfe_pkg::ST_ROW;
                    break;
                end
                node = longint'(child_mem[int'(idx)]) - 1;
                if (node < 0 || node >= dtrfe_pkg::TreeRowsDef) begin
                    r.status = dtrfe_pkg::ST_ROW;
                    break;
                end
            end
        end
        r.row = last[10:0];
        if (r.status == dtrfe_pkg::ST_OK)
            for (int k = 0; k < 8; k++)
                r.words[k] = tree_mem[int'(last) * dtrfe_pkg::TreeCols + 2 + k];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_leaf_result want;
        t_leaf_result got;
        if (i_rst_n) begin
            if (o_valid) begin
                got.status = o_status;
                got.row = o_leaf_row;
                got.words = {o_leaf_mean_5, o_leaf_mean_4, o_leaf_mean_3, o_leaf_mean_2,
                             o_leaf_mean_1, o_leaf_mean_0, o_leaf_trace, o_leaf_fg_prob};
                if (leaf_q.size() == 0) begin
                    $error("result transfer with no evaluate outstanding");
                    mismatch_count++;
                end else begin
                    want = leaf_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.row !== want.row) begin
                        $error("leaf_row: expected %0d, got %0d", want.row, got.row);
                        mismatch_count++;
                    end
                    for (int k = 0; k < 8; k++)
                        if (got.words[k] !== want.words[k]) begin
                            $error("%s: expected %h, got %h", word_names[k], want.words[k],
                                   got.words[k]);
                            mismatch_count++;
                        end
                end
            end
            if (start && !busy) begin
                case (i_req_type)
                    dtrfe_pkg::REQ_TREE: begin
                        if (i_addr_row < dtrfe_pkg::TreeRowsDef
                                && i_addr_col < dtrfe_pkg::TreeCols)
                            tree_mem[int'(i_addr_row) * dtrfe_pkg::TreeCols
                                     + int'(i_addr_col)] = i_write_value;
                    end
                    dtrfe_pkg::REQ_MAP: begin
                        if (i_addr_row < dtrfe_pkg::MapEntriesDef)
                            child_mem[i_addr_row] = i_write_value[11:0];
                    end
                    dtrfe_pkg::REQ_DEPTH: begin
                        if (i_addr_row < dtrfe_pkg::ImgHDef && i_addr_col < dtrfe_pkg::ImgWDef)
                            depth_img[int'(i_addr_row) * dtrfe_pkg::ImgWDef
                                      + int'(i_addr_col)] = i_write_value;
                    end
                    dtrfe_pkg::REQ_MASK: begin
                        if (i_addr_row < dtrfe_pkg::ImgHDef && i_addr_col < dtrfe_pkg::ImgWDef)
                            mask_img[int'(i_addr_row) * dtrfe_pkg::ImgWDef
                                     + int'(i_addr_col)] = i_write_value[15:0];
                    end
                    dtrfe_pkg::REQ_EVAL:
                        leaf_q.push_back(walk_tree(i_start_row, i_roi_x, i_roi_y));
                    default: ;
                endcase
            end
        end
        pending_count <= leaf_q.size();
    end
endmodule

// ----- tb/decision_tree_rect_feature_eval_test.sv -----
`timescale 1ns / 1ps
module decision_tree_rect_feature_eval_test;
    localparam int Phases        = 5;
    localparam int WalksPerPhase = 60;
    localparam int PoolSize      = 12;
    localparam int WatchLimit    = 20000;
    localparam int DrainCycles   = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic        [2:0]  i_req_type = '0;
    logic        [11:0] i_addr_row = '0;
    logic        [6:0]  i_addr_col = '0;
    logic signed [31:0] i_write_value = '0;
    logic        [10:0] i_start_row = '0;
    logic        [6:0]  i_roi_x = '0;
    logic        [6:0]  i_roi_y = '0;
    logic               o_valid;
    logic        [1:0]  o_status;
    logic        [10:0] o_leaf_row;
    logic signed [31:0] o_leaf_fg_prob, o_leaf_trace;
    logic signed [31:0] o_leaf_mean_0, o_leaf_mean_1, o_leaf_mean_2;
    logic signed [31:0] o_leaf_mean_3, o_leaf_mean_4, o_leaf_mean_5;
    int                 mismatches;
    int                 leaves_pending;
    int                 quiet_cycles = 0;

    // image coordinates that get written; every rectangle corner that stays on the image lands on one
    int          grid [8] = '{0, 1, 2, 3, 5, 64, 126, 127};
    logic [10:0] pool_rows [PoolSize];
    logic [6:0]  rx, ry;
    bit          start_hi = 1'b0;
    int          burst_left = 0;

    always #6 i_clk = ~i_clk;

    decision_tree_rect_feature_eval dut (.*);

    leaf_walk_checker u_checker (
        .o_mismatches(mismatches),
        .o_leaves_pending(leaves_pending),
        .*
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WatchLimit) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic sender_halt();
        if (start_hi) begin
            start <= 1'b0;
            start_hi = 1'b0;
        end
    endtask

    task automatic transfer(input logic [2:0] t, input logic [11:0] r, input logic [6:0] c,
                            input logic [31:0] v, input logic [10:0] s);
        int gap;
        i_req_type <= t;
        i_addr_row <= r;
        i_addr_col <= c;
        i_write_value <= v;
        i_start_row <= s;
        i_roi_x <= rx;
        i_roi_y <= ry;
        start <= 1'b1;
        start_hi = 1'b1;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                sender_halt();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_pixel(input int gx, input int gy);
        logic [31:0] d;
        logic [31:0] m;
        d = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 200000));
        m = ($urandom_range(0, 2) != 0) ? $urandom : 32'($urandom_range(0, 300));
        transfer(dtrfe_pkg::REQ_DEPTH, 12'(gy), 7'(gx), d, '0);
        transfer(dtrfe_pkg::REQ_MASK, 12'(gy), 7'(gx), m, '0);
    endtask

    function automatic logic [31:0] child_ref(input int role);
        logic [31:0] v;
        int pick;
        v = $urandom;
        pick = $urandom_range(0, 9);
        if (role == 4 || pick == 0) v[11:0] = '0;
        else if (pick == 1) v[11:0] = 12'($urandom_range(dtrfe_pkg::TreeRowsDef + 1, 4095));
        else v[11:0] = 12'(pool_rows[$urandom_range(0, PoolSize - 1)] + 1);
        return v;
    endfunction

    // roles: 0 leaf, 1 self loop, 2 negative node id, 3 off-image corner,
    // 4 null child, 5 node id zero, 8 node id at the map's top, rest leaf or random
    task automatic build_tree();
        int w [12];
        int keys [$];
        int hits [$];
        int k;
        int role;
        logic [31:0] v;
        for (int i = 0; i < PoolSize; i++) begin
            if (i == 6) pool_rows[i] = '0;
            else if (i == 7) pool_rows[i] = 11'(dtrfe_pkg::TreeRowsDef - 1);
            else begin
                do begin
                    pool_rows[i] = 11'($urandom_range(1, dtrfe_pkg::TreeRowsDef - 2));
                    hits = '{};
                    for (int j = 0; j < i; j++) if (pool_rows[j] == pool_rows[i]) hits.push_back(j);
                end while (hits.size() != 0);
            end
        end
        for (int i = 0; i < PoolSize; i++) begin
            role = (i <= 5 || i == 8) ? i : (($urandom_range(0, 99) < 35) ? 0 : 9);
            for (int j = 0; j < 12; j++) w[j] = int'(rand_word());
            if (role == 0) begin
                if (w[1] == -1) w[1] = 0;
            end else begin
                w[1] = -1;
                for (int b = 0; b < 2; b++) begin
                    w[2 + 2 * b] = grid[$urandom_range(0, 7)] - int'(rx);
                    w[3 + 2 * b] = grid[$urandom_range(0, 7)] - int'(ry);
                    w[6 + 2 * b] = grid[$urandom_range(0, 7)] - (w[2 + 2 * b] + int'(rx));
                    w[7 + 2 * b] = grid[$urandom_range(0, 7)] - (w[3 + 2 * b] + int'(ry));
                end
                if (role == 3 || $urandom_range(0, 9) == 0) begin
                    k = $urandom_range(2, 9);
                    w[k] += ($urandom_range(0, 1) != 0) ? 300 : -300;
                end
                if ($urandom_range(0, 1) != 0) w[11] = int'($urandom_range(0, 1 << 17)) - (1 << 16);
                if (role == 2) k = -int'($urandom_range(1, 1000));
                else if (role == 5) k = 0;
                else if (role == 8) k = dtrfe_pkg::TreeRowsDef;
                else begin
                    do begin
                        k = $urandom_range(1, dtrfe_pkg::TreeRowsDef - 1);
                        hits = keys.find_index(x) with (x == k);
                    end while (hits.size() != 0);
                end
                keys.push_back(k);
                w[0] = k;
            end
            for (int j = 0; j < 12; j++)
                transfer(dtrfe_pkg::REQ_TREE, 12'(pool_rows[i]), 7'(j), w[j], '0);
            if (role != 0) begin
                for (int d = -1; d <= 0; d++) begin
                    if (2 * k + d >= 0 && 2 * k + d < dtrfe_pkg::MapEntriesDef) begin
                        if (role == 1) begin
                            v = $urandom;
                            v[11:0] = 12'(pool_rows[i] + 1);
                        end else begin
                            v = child_ref(role);
                        end
                        transfer(dtrfe_pkg::REQ_MAP, 12'(2 * k + d), '0, v, '0);
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx = '0;
        ry = '0;
        for (int gy = 0; gy < 8; gy++)
            for (int gx = 0; gx < 8; gx++) write_pixel(grid[gx], grid[gy]);
        // writes that land outside every store and unknown request codes
        transfer(3'd5, 12'hfff, 7'h7f, $urandom, 11'h7ff);
        transfer(3'd6, '0, '0, $urandom, '0);
        transfer(3'd7, 12'($urandom), 7'($urandom), $urandom, 11'($urandom));
        transfer(dtrfe_pkg::REQ_TREE, 12'd5, 7'd12, $urandom, '0);
        transfer(dtrfe_pkg::REQ_TREE, 12'd9, 7'd127, $urandom, '0);
        transfer(dtrfe_pkg::REQ_TREE, 12'(dtrfe_pkg::TreeRowsDef), 7'd3, $urandom, '0);
        transfer(dtrfe_pkg::REQ_DEPTH, 12'(dtrfe_pkg::ImgHDef), 7'd0, $urandom, '0);
        transfer(dtrfe_pkg::REQ_MASK, 12'hfff, 7'd1, $urandom, '0);
        for (int ph = 0; ph < Phases; ph++) begin
            sender_halt();
            do @(posedge i_clk); while (leaves_pending != 0);
            if (ph == 0) begin
                rx = '0;
                ry = '0;
            end else if (ph == 1) begin
                rx = 7'h7f;
                ry = 7'h7f;
            end else begin
                rx = 7'($urandom);
                ry = 7'($urandom);
            end
            build_tree();
            for (int i = 0; i < PoolSize; i++)
                transfer(dtrfe_pkg::REQ_EVAL, '0, '0, '0, pool_rows[i]);
            for (int n = 0; n < WalksPerPhase; n++) begin
                case ($urandom_range(0, 19))
                    0: transfer(3'($urandom_range(5, 7)), 12'($urandom), 7'($urandom), $urandom,
                                11'($urandom));
                    1: write_pixel(grid[$urandom_range(0, 7)], grid[$urandom_range(0, 7)]);
                    default: ;
                endcase
                transfer(dtrfe_pkg::REQ_EVAL, 12'($urandom), 7'($urandom), $urandom,
                         pool_rows[$urandom_range(0, PoolSize - 1)]);
            end
        end
        sender_halt();
        do @(posedge i_clk); while (leaves_pending != 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && leaves_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
